[src/owsr_pkg.sv]
package owsr_pkg;

    localparam int ROM_W   = 64;
    localparam int IDX_W   = 6;
    localparam int FORK_W  = 7;
    localparam int COUNT_W = 8;
    localparam int CRC_W   = 8;

    localparam logic [FORK_W-1:0]  NONE_FORK       = 7'h7F;
    localparam logic [IDX_W-1:0]   LAST_INDEX      = 6'd63;
    localparam logic [CRC_W-1:0]   CRC_POLY        = 8'h8C;
    localparam logic [COUNT_W-1:0] MAX_DEV_RESET   = 8'd20;
    localparam logic [COUNT_W-1:0] COUNT_SATURATED = 8'hFF;

    typedef enum logic [1:0] {
        CMD_NEW_SEARCH = 2'd0,
        CMD_PASS_START = 2'd1,
        CMD_BIT_PAIR   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MORE    = 3'd1,
        ST_DONE    = 3'd2,
        ST_NOPRES  = 3'd3,
        ST_NORESP  = 3'd4,
        ST_CRCERR  = 3'd5,
        ST_NOPASS  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0] cmd;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } t_in_item;

    typedef struct packed {
        logic               write_bit;
        t_status            status;
        logic [ROM_W-1:0]   rom_id;
        logic [COUNT_W-1:0] device_count;
        logic [IDX_W-1:0]   bit_index;
    } t_out_item;

    // One step of the reflected Dallas CRC-8.
    function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] crc,
                                                    input logic bit_in);
        logic [CRC_W-1:0] shifted;
        shifted = {1'b0, crc[CRC_W-1:1]};
        if (crc[0] ^ bit_in) begin
            shifted = shifted ^ CRC_POLY;
        end
        return shifted;
    endfunction

endpackage

[src/owsr_if.sv]
interface owsr_in_if;
    import owsr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface owsr_out_if;
    import owsr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface owsr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/owsr_dir.sv]
module owsr_dir (
    input  logic                        i_id_bit,
    input  logic                        i_complement_bit,
    input  logic                        i_prev_bit,
    input  logic [owsr_pkg::FORK_W-1:0] i_last_fork,
    input  logic [owsr_pkg::IDX_W-1:0]  i_index,
    output logic                        o_write_bit,
    output logic                        o_zero_fork
);
    import owsr_pkg::*;

    logic [FORK_W-1:0] index_ext;

    assign index_ext = {1'b0, i_index};

    always_comb begin
        o_write_bit = 1'b0;
        o_zero_fork = 1'b0;
        if (i_id_bit != i_complement_bit) begin
            o_write_bit = i_id_bit;
        end else begin
            // Below the last discrepancy the previous code is followed, at it the
            // one branch is taken, and beyond it the zero branch.
            if (i_last_fork != NONE_FORK && i_last_fork > index_ext) begin
                o_write_bit = i_prev_bit;
            end else if (i_last_fork == index_ext) begin
                o_write_bit = 1'b1;
            end else begin
                o_write_bit = 1'b0;
            end
            o_zero_fork = !o_write_bit;
        end
    end

endmodule

[src/onewire_search_rom.sv]
// 1-Wire ROM search engine.
// Requests arrive on i_in: a new-search command, a pass start carrying the
// presence result of a bus reset, or a bit pair with the id and complement
// read slots of the current ROM bit. Every request gives exactly one result
// on o_out: the direction bit to write back, a status, the ROM register,
// the device count and the bit position the result belongs to.
// The maximum device count is written on i_cfg, which is always ready; write
// it only while no request is in flight.
// Each request is worked out in the cycle it is accepted and its result is
// held in the output register. One request is accepted in every cycle while
// the receiver takes each result. The rate is set by the single output
// register: i_in.ready is high while that register is empty or is being taken.
// When the receiver stalls, the result stays in the output register and no
// further request is accepted until it is taken.
// After reset the search state is cleared, no pass is active, no result is
// pending and the device limit is 20.
module onewire_search_rom (
    input  logic       i_clk,
    input  logic       i_rst_n,
    owsr_cfg_if.sink   i_cfg,
    owsr_in_if.sink    i_in,
    owsr_out_if.source o_out
);
    import owsr_pkg::*;

    logic [COUNT_W-1:0] r_max_devices;
    logic [ROM_W-1:0]   r_rom, n_rom;
    logic [FORK_W-1:0]  r_last_fork, n_last_fork;
    logic [FORK_W-1:0]  r_newest_fork, n_newest_fork;
    logic [IDX_W-1:0]   r_position, n_position;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [COUNT_W-1:0] r_found, n_found;
    logic               r_pass_active, n_pass_active;
    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic               accept;
    logic [IDX_W-1:0]   index;
    logic               dir_write_bit;
    logic               dir_zero_fork;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    owsr_dir u_dir (
        .i_id_bit         (i_in.data.id_bit),
        .i_complement_bit (i_in.data.complement_bit),
        .i_prev_bit       (r_rom[r_position]),
        .i_last_fork      (r_last_fork),
        .i_index          (r_position),
        .o_write_bit      (dir_write_bit),
        .o_zero_fork      (dir_zero_fork)
    );

    always_comb begin
        n_rom         = r_rom;
        n_last_fork   = r_last_fork;
        n_newest_fork = r_newest_fork;
        n_position    = r_position;
        n_crc         = r_crc;
        n_found       = r_found;
        n_pass_active = r_pass_active;
        n_out.write_bit = 1'b0;
        n_out.status    = ST_OK;
        index           = r_position;
        case (i_in.data.cmd)
            CMD_NEW_SEARCH: begin
                n_rom         = '0;
                n_last_fork   = NONE_FORK;
                n_newest_fork = NONE_FORK;
                n_position    = '0;
                n_crc         = '0;
                n_found       = '0;
                n_pass_active = 1'b0;
                index         = '0;
            end
            CMD_PASS_START: begin
                n_position    = '0;
                n_newest_fork = NONE_FORK;
                n_crc         = '0;
                index         = '0;
                n_pass_active = i_in.data.presence;
                if (!i_in.data.presence) begin
                    n_out.status = ST_NOPRES;
                end
            end
            CMD_BIT_PAIR: begin
                if (!r_pass_active) begin
                    n_out.status = ST_NOPASS;
                end else if (i_in.data.id_bit && i_in.data.complement_bit) begin
                    n_found       = '0;
                    n_last_fork   = NONE_FORK;
                    n_pass_active = 1'b0;
                    n_out.status  = ST_NORESP;
                end else begin
                    n_out.write_bit = dir_write_bit;
                    if (dir_zero_fork) begin
                        n_newest_fork = {1'b0, r_position};
                    end
                    n_rom[r_position] = dir_write_bit;
                    n_crc = crc_shift(r_crc, dir_write_bit);
                    if (r_position != LAST_INDEX) begin
                        n_position = r_position + 1'b1;
                    end else begin
                        n_pass_active = 1'b0;
                        n_position    = '0;
                        if (n_crc != '0) begin
                            n_found      = '0;
                            n_last_fork  = NONE_FORK;
                            n_out.status = ST_CRCERR;
                        end else begin
                            if (r_found != COUNT_SATURATED) begin
                                n_found = r_found + 1'b1;
                            end
                            // A zero limit behaves as one, which the compare
                            // already gives since the count is at least one here.
                            if (n_found >= r_max_devices || n_newest_fork == NONE_FORK) begin
                                n_last_fork  = NONE_FORK;
                                n_out.status = ST_DONE;
                            end else begin
                                n_last_fork  = n_newest_fork;
                                n_out.status = ST_MORE;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.rom_id       = n_rom;
        n_out.device_count = n_found;
        n_out.bit_index    = index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_devices <= MAX_DEV_RESET;
        end else if (i_cfg.valid) begin
            r_max_devices <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom         <= '0;
            r_last_fork   <= NONE_FORK;
            r_newest_fork <= NONE_FORK;
            r_position    <= '0;
            r_crc         <= '0;
            r_found       <= '0;
            r_pass_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_rom         <= n_rom;
                r_last_fork   <= n_last_fork;
                r_newest_fork <= n_newest_fork;
                r_position    <= n_position;
                r_crc         <= n_crc;
                r_found       <= n_found;
                r_pass_active <= n_pass_active;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import owsr_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int BODY_W          = ROM_W - CRC_W;
    localparam int BUS_MAX         = 8;
    localparam int IDLE_MAX        = 13;
    localparam int HOLD_CYCLES     = 300;
    localparam int STUCK_LIMIT     = 2000;
    localparam int RANDOM_REQUESTS = 100;
    localparam int MAX_REPORTS     = 10;

    logic clk;
    logic rst_n;

    owsr_cfg_if cfg_if ();
    owsr_in_if  in_if ();
    owsr_out_if out_if ();

    onewire_search_rom u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Search state as the engine should hold it.
    logic [ROM_W-1:0]   m_rom;
    logic [FORK_W-1:0]  m_last_fork;
    logic [FORK_W-1:0]  m_newest_fork;
    logic [IDX_W-1:0]   m_pos;
    logic [CRC_W-1:0]   m_crc;
    logic [COUNT_W-1:0] m_found;
    logic [COUNT_W-1:0] m_max;
    logic               m_active;

    t_out_item        expected_results[$];
    logic [ROM_W-1:0] bus_roms[$];

    int requests_sent = 0;
    int error_count   = 0;
    int hold_request  = 0;
    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [CRC_W-1:0] crc8_step(input logic [CRC_W-1:0] crc,
                                                   input logic bit_in);
        logic feedback;
        feedback = crc[0] ^ bit_in;
        crc = {1'b0, crc[CRC_W-1:1]};
        return feedback ? (crc ^ CRC_POLY) : crc;
    endfunction

    function automatic logic [ROM_W-1:0] make_rom_code(input logic [BODY_W-1:0] body);
        logic [CRC_W-1:0] crc;
        int i;
        crc = '0;
        for (i = 0; i < BODY_W; i++) crc = crc8_step(crc, body[i]);
        return {crc, body};
    endfunction

    function automatic t_out_item predict_search_step(input t_in_item req);
        t_out_item res;
        t_status st;
        logic [IDX_W-1:0] idx;
        logic wbit;
        st   = ST_OK;
        wbit = 1'b0;
        idx  = m_pos;
        case (req.cmd)
            CMD_NEW_SEARCH: begin
                m_rom         = '0;
                m_last_fork   = NONE_FORK;
                m_newest_fork = NONE_FORK;
                m_pos         = '0;
                m_crc         = '0;
                m_found       = '0;
                m_active      = 1'b0;
                idx           = '0;
            end
            CMD_PASS_START: begin
                m_pos         = '0;
                m_newest_fork = NONE_FORK;
                m_crc         = '0;
                idx           = '0;
                m_active      = req.presence;
                if (!req.presence) st = ST_NOPRES;
            end
            CMD_BIT_PAIR: begin
                if (!m_active) begin
                    st = ST_NOPASS;
                end else if (req.id_bit && req.complement_bit) begin
                    m_found     = '0;
                    m_last_fork = NONE_FORK;
                    m_active    = 1'b0;
                    st          = ST_NORESP;
                end else begin
                    if (req.id_bit != req.complement_bit) begin
                        wbit = req.id_bit;
                    end else begin
                        // Below the last discrepancy follow the previous code, at it
                        // take the one branch, beyond it take zero.
                        if (m_last_fork != NONE_FORK && m_last_fork > {1'b0, idx}) begin
                            wbit = m_rom[idx];
                        end else if (m_last_fork == {1'b0, idx}) begin
                            wbit = 1'b1;
                        end
                        if (!wbit) m_newest_fork = {1'b0, idx};
                    end
                    m_rom[idx] = wbit;
                    m_crc = crc8_step(m_crc, wbit);
                    if (idx != LAST_INDEX) begin
                        m_pos = idx + 1'b1;
                    end else begin
                        m_active = 1'b0;
                        m_pos    = '0;
                        if (m_crc != '0) begin
                            m_found     = '0;
                            m_last_fork = NONE_FORK;
                            st          = ST_CRCERR;
                        end else begin
                            if (m_found != COUNT_SATURATED) m_found = m_found + 1'b1;
                            if (m_found >= m_max || m_newest_fork == NONE_FORK) begin
                                m_last_fork = NONE_FORK;
                                st          = ST_DONE;
                            end else begin
                                m_last_fork = m_newest_fork;
                                st          = ST_MORE;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.write_bit    = wbit;
        res.status       = st;
        res.rom_id       = m_rom;
        res.device_count = m_found;
        res.bit_index    = idx;
        return res;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic presence,
                                input logic id_bit, input logic complement_bit,
                                output t_out_item predicted);
        t_in_item req;
        int gap;
        req.cmd            = cmd;
        req.presence       = presence;
        req.id_bit         = id_bit;
        req.complement_bit = complement_bit;
        gap = sender_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= req;
        @(posedge clk);
        while (in_if.ready !== 1'b1) @(posedge clk);
        predicted = predict_search_step(req);
        expected_results.push_back(predicted);
        requests_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_devices(input logic [COUNT_W-1:0] value);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        cfg_if.valid <= 1'b0;
        m_max = value;
    endtask

    task automatic build_bus(input int count);
        logic [BODY_W-1:0] body;
        logic [BODY_W-1:0] mask;
        int k;
        int j;
        bus_roms.delete();
        repeat (count) begin
            body = BODY_W'({$urandom, $urandom});
            if (bus_roms.size() > 0 && $urandom_range(0, 1)) begin
                // Share a prefix with an earlier device so that the forks fall deep.
                k    = $urandom_range(0, BODY_W - 1);
                j    = $urandom_range(0, bus_roms.size() - 1);
                mask = BODY_W'(({$urandom, $urandom} | 64'd1) << k);
                body = bus_roms[j][BODY_W-1:0] ^ mask;
            end
            bus_roms.push_back(make_rom_code(body));
        end
    endtask

    // One pass over the bus: the slots are the wired-AND of the devices still
    // selected, and a device drops out when its bit differs from the one written.
    task automatic run_pass(input int noise_pct, output t_status outcome);
        t_out_item res;
        logic [BUS_MAX-1:0] sel;
        logic id_slot;
        logic cmp_slot;
        int idx;
        int d;
        outcome = ST_OK;
        send_request(CMD_PASS_START,
                     (bus_roms.size() > 0) ^ ($urandom_range(0, 99) < noise_pct),
                     1'($urandom), 1'($urandom), res);
        if (res.status != ST_OK) begin
            outcome = res.status;
            return;
        end
        sel = '1;
        idx = 0;
        while (idx < ROM_W) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                case ($urandom_range(0, 2))
                    0: send_request(CMD_RESERVED, 1'($urandom), 1'($urandom),
                                    1'($urandom), res);
                    1: begin
                        send_request(CMD_PASS_START, 1'b1, 1'($urandom), 1'($urandom),
                                     res);
                        sel = '1;
                        idx = 0;
                        continue;
                    end
                    default: begin
                        // A new search in the middle of a pass abandons the search.
                        send_request(CMD_NEW_SEARCH, 1'($urandom), 1'($urandom),
                                     1'($urandom), res);
                        outcome = ST_NOPASS;
                        return;
                    end
                endcase
            end
            id_slot  = 1'b1;
            cmp_slot = 1'b1;
            for (d = 0; d < bus_roms.size(); d++) begin
                if (sel[d]) begin
                    if (bus_roms[d][idx]) cmp_slot = 1'b0;
                    else id_slot = 1'b0;
                end
            end
            if ($urandom_range(0, 99) < noise_pct) begin
                if ($urandom_range(0, 1)) id_slot = ~id_slot;
                else cmp_slot = ~cmp_slot;
            end
            send_request(CMD_BIT_PAIR, 1'($urandom), id_slot, cmp_slot, res);
            if (res.status != ST_OK) begin
                outcome = res.status;
                return;
            end
            for (d = 0; d < bus_roms.size(); d++) begin
                if (bus_roms[d][idx] != res.write_bit) sel[d] = 1'b0;
            end
            idx++;
        end
    endtask

    task automatic run_search(input int noise_pct);
        t_out_item res;
        t_status outcome;
        int passes;
        send_request(CMD_NEW_SEARCH, 1'($urandom), 1'($urandom), 1'($urandom), res);
        passes = 0;
        do begin
            run_pass(noise_pct, outcome);
            passes++;
        end while (outcome == ST_MORE && passes < 16);
    endtask

    task automatic test_directed();
        t_out_item res;
        send_request(CMD_NEW_SEARCH, 1'b1, 1'b1, 1'b1, res);
        send_request(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b0, res);
        send_request(CMD_RESERVED, 1'b1, 1'b1, 1'b1, res);
        send_request(CMD_PASS_START, 1'b0, 1'b1, 1'b1, res);
        send_request(CMD_BIT_PAIR, 1'b1, 1'b0, 1'b1, res);
        send_request(CMD_PASS_START, 1'b1, 1'b0, 1'b0, res);
        send_request(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b0, res);
        send_request(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b1, res);
        send_request(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b0, res);
        send_request(CMD_PASS_START, 1'b1, 1'b1, 1'b1, res);
        send_request(CMD_BIT_PAIR, 1'b1, 1'b0, 1'b0, res);
        send_request(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b1, res);
        send_request(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b0, res);
        send_request(CMD_NEW_SEARCH, 1'b0, 1'b0, 1'b0, res);
    endtask

    task automatic test_full_passes();
        logic [BODY_W-1:0] body;
        bus_roms.delete();
        bus_roms.push_back(make_rom_code('0));
        run_search(0);
        bus_roms[0] = make_rom_code('1);
        run_search(0);
        // Two codes whose bodies differ only in the last body bit.
        body = BODY_W'({$urandom, $urandom});
        bus_roms[0] = make_rom_code(body);
        bus_roms.push_back(make_rom_code(body ^ (56'd1 << (BODY_W - 1))));
        run_search(0);
    endtask

    task automatic test_crc_error();
        logic [ROM_W-1:0] good;
        t_out_item res;
        t_status outcome;
        good = make_rom_code(BODY_W'({$urandom, $urandom}));
        bus_roms.delete();
        bus_roms.push_back(good);
        send_request(CMD_NEW_SEARCH, 1'b0, 1'b0, 1'b0, res);
        run_pass(0, outcome);
        bus_roms[0] = good ^ (64'd1 << $urandom_range(BODY_W, ROM_W - 1));
        run_pass(0, outcome);
        bus_roms[0] = good;
        run_pass(0, outcome);
    endtask

    task automatic test_device_limit();
        build_bus(5);
        write_max_devices(8'd1);
        run_search(0);
        write_max_devices(COUNT_SATURATED);
        run_search(0);
        write_max_devices(8'd3);
        run_search(0);
    endtask

    task automatic test_backpressure();
        t_out_item res;
        t_status outcome;
        sender_idle = 1'b0;
        build_bus(3);
        hold_request = HOLD_CYCLES;
        send_request(CMD_NEW_SEARCH, 1'b0, 1'b0, 1'b0, res);
        run_pass(0, outcome);
        // Stop sending halfway through the search until every result is back.
        drain_results();
        run_pass(0, outcome);
        run_pass(0, outcome);
        sender_idle = 1'b1;
    endtask

    task automatic test_random();
        t_out_item res;
        int goal;
        int noise;
        goal = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < goal) begin
            sender_idle   = ($urandom_range(0, 9) < 7);
            receiver_idle = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_max_devices(8'd1);
                    1: write_max_devices(COUNT_SATURATED);
                    default: write_max_devices(8'($urandom_range(1, 255)));
                endcase
            end
            build_bus($urandom_range(0, 6));
            noise = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
            run_search(noise);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                                 1'($urandom), res);
                end
            end
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    initial begin
        rst_n        <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        m_rom         = '0;
        m_last_fork   = NONE_FORK;
        m_newest_fork = NONE_FORK;
        m_pos         = '0;
        m_crc         = '0;
        m_found       = '0;
        m_max         = MAX_DEV_RESET;
        m_active      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_passes();
        test_crc_error();
        test_device_limit();
        test_backpressure();
        test_random();
        drain_results();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: takes each result, after a random stall while receiver_idle is set, and checks it.
    initial begin
        t_out_item exp_res;
        t_out_item got;
        int gap;
        out_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                out_if.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            gap = receiver_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (out_if.valid !== 1'b1) @(posedge clk);
            got = out_if.data;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected result: wbit=%0b st=%0d rom=%h cnt=%0d idx=%0d",
                             got.write_bit, got.status, got.rom_id, got.device_count,
                             got.bit_index);
                end
            end else begin
                exp_res = expected_results.pop_front();
                if (got.write_bit !== exp_res.write_bit || got.status !== exp_res.status ||
                    got.rom_id !== exp_res.rom_id ||
                    got.device_count !== exp_res.device_count ||
                    got.bit_index !== exp_res.bit_index) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: expected wbit=%0b st=%0d rom=%h cnt=%0d idx=%0d",
                                 exp_res.write_bit, exp_res.status, exp_res.rom_id,
                                 exp_res.device_count, exp_res.bit_index);
                        $display("          actual   wbit=%0b st=%0d rom=%h cnt=%0d idx=%0d",
                                 got.write_bit, got.status, got.rom_id, got.device_count,
                                 got.bit_index);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no request, result or write moves for too long.
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("Verification failed");
        $finish;
    end

endmodule
